### hw/rtl/int8_mlp_score_engine_unit_assert.svh
// assertion macros for the int8 mlp score engine
// used by the top level, no other dependencies
`ifndef INT8_MLP_SCORE_ENGINE_UNIT_ASSERT_SVH
`define INT8_MLP_SCORE_ENGINE_UNIT_ASSERT_SVH
`ifndef SYNTH
`define IMLP_ASSERT_IMPL(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("imlp assertion failed");
`define IMLP_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("imlp assertion failed");
`else
`define IMLP_ASSERT_IMPL(name, clk, rstn, ante, cons)
`define IMLP_ASSERT_NEXT(name, clk, rstn, ante, cons)
`endif
`endif

### hw/rtl/imlp_pkg.sv
// shared types and constants of the int8 mlp score engine
// no dependencies
`timescale 1ns / 1ps
package imlp_pkg;
    localparam int FEATURES   = 4;
    localparam int LOAD_IDX_W = 8;

    localparam logic [2:0] CFG_W0_BYTES = 3'd0;
    localparam logic [2:0] CFG_B0_WORDS = 3'd1;
    localparam logic [2:0] CFG_W1_BYTES = 3'd2;
    localparam logic [2:0] CFG_B1_WORDS = 3'd3;
    localparam logic [2:0] CFG_IN_MULT  = 3'd4;
    localparam logic [2:0] CFG_HID_MULT = 3'd5;
    localparam logic [2:0] CFG_OUT_MULT = 3'd6;

    typedef logic signed [7:0] t_int8;
    typedef t_int8 [FEATURES-1:0] t_feat_vec;

    typedef enum logic [1:0] {
        LK_W0,
        LK_B0,
        LK_W1,
        LK_B1
    } t_load_kind;

    typedef struct packed {
        logic                  en;
        t_load_kind            kind;
        logic [LOAD_IDX_W-1:0] idx;
        logic [3:0]            be;
        logic [31:0]           word;
    } t_load_wr;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCALE,
        ST_RUN,
        ST_OUT
    } t_state;
endpackage

### hw/rtl/imlp_in_if.sv
// input item channel of the int8 mlp score engine
// no dependencies
`timescale 1ns / 1ps
interface imlp_in_if;
    logic               valid;
    logic               ready;
    logic               mode;
    logic signed [31:0] order_flow;
    logic signed [15:0] imbalance;
    logic        [31:0] burst;
    logic        [31:0] volatility;
    logic        [31:0] weight_word;
    logic               last_in;

    modport source (output valid, mode, order_flow, imbalance, burst, volatility,
                    weight_word, last_in, input ready);
    modport sink (input valid, mode, order_flow, imbalance, burst, volatility,
                  weight_word, last_in, output ready);
endinterface

### hw/rtl/imlp_out_if.sv
// result item channel of the int8 mlp score engine
// no dependencies
`timescale 1ns / 1ps
interface imlp_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] score;
    logic               last_out;

    modport source (output valid, score, last_out, input ready);
    modport sink (input valid, score, last_out, output ready);
endinterface

### hw/rtl/imlp_cfg_if.sv
// configuration write channel of the int8 mlp score engine
// no dependencies
`timescale 1ns / 1ps
interface imlp_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/imlp_loader.sv
// load word sequencer: places weight words into the neuron cells and the output bias
// depends on imlp_pkg
`timescale 1ns / 1ps
module imlp_loader import imlp_pkg::*; #(
    parameter int HIDDEN = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_wr,
    input  logic [31:0] i_word,
    input  logic [7:0] i_w0_bytes,
    input  logic [5:0] i_b0_words,
    input  logic [5:0] i_w1_bytes,
    input  logic [2:0] i_b1_words,
    output t_load_wr   o_load
);
    localparam int S0_MAX = HIDDEN;
    localparam int S2_MAX = (HIDDEN + 3) / 4;
    localparam int POS_W  = $clog2(HIDDEN + 63 + S2_MAX + 7 + 1);
    localparam int BI_W   = POS_W + 2;

    logic [POS_W-1:0] r_pos, n_pos;
    logic [6:0]       s0_raw;
    logic [4:0]       s2_raw;
    logic [POS_W-1:0] s0, s2, total, p0, pb, p1, p2, p_inc;
    logic [BI_W-1:0]  bidx;

    always_comb begin
        s0_raw = 7'((({1'b0, i_w0_bytes}) + 9'd3) >> 2);
        s2_raw = 5'((({1'b0, i_w1_bytes}) + 7'd3) >> 2);
        s0 = (POS_W'(s0_raw) > POS_W'(S0_MAX)) ? POS_W'(S0_MAX) : POS_W'(s0_raw);
        s2 = (POS_W'(s2_raw) > POS_W'(S2_MAX)) ? POS_W'(S2_MAX) : POS_W'(s2_raw);
        total = s0 + POS_W'(i_b0_words) + s2 + POS_W'(i_b1_words);
        p0 = (r_pos >= total) ? '0 : r_pos;
        pb = p0 - s0;
        p1 = pb - POS_W'(i_b0_words);
        p2 = p1 - s2;
        p_inc = p0 + 1'b1;

        o_load.en   = 1'b0;
        o_load.kind = LK_W0;
        o_load.idx  = LOAD_IDX_W'(p0);
        o_load.be   = '0;
        o_load.word = i_word;
        bidx        = '0;
        n_pos       = r_pos;

        if (i_wr && total != '0) begin
            n_pos = (p_inc >= total) ? '0 : p_inc;
            priority if (p0 < s0) begin
                o_load.en = 1'b1;
                for (int k = 0; k < 4; k++) begin
                    bidx = {p0, 2'b00} + BI_W'(k);
                    o_load.be[k] = bidx < BI_W'(i_w0_bytes);
                end
            end else if (pb < POS_W'(i_b0_words)) begin
                o_load.kind = LK_B0;
                o_load.idx  = LOAD_IDX_W'(pb);
                o_load.en   = pb < POS_W'(HIDDEN);
            end else if (p1 < s2) begin
                o_load.kind = LK_W1;
                o_load.idx  = LOAD_IDX_W'(p1);
                o_load.en   = 1'b1;
                for (int k = 0; k < 4; k++) begin
                    bidx = {p1, 2'b00} + BI_W'(k);
                    o_load.be[k] = (bidx < BI_W'(i_w1_bytes)) && (bidx < BI_W'(HIDDEN));
                end
            end else if (p2 == '0) begin
                o_load.kind = LK_B1;
                o_load.en   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end
endmodule

### hw/rtl/imlp_cell.sv
// one hidden neuron cell: dot product, relu, requantize, output mac
// depends on imlp_pkg
`timescale 1ns / 1ps
module imlp_cell import imlp_pkg::*; #(
    parameter int CELL_IDX = 0
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_load_wr    i_load,
    input  logic [31:0] i_hidden_mult,
    input  t_feat_vec   i_x,
    input  logic [31:0] i_acc,
    output t_feat_vec   o_x,
    output logic [31:0] o_acc
);
    localparam int W1_WORD = CELL_IDX / 4;
    localparam int W1_BYTE = CELL_IDX % 4;

    t_int8        r_w0 [FEATURES];
    logic [31:0]  r_b0;
    t_int8        r_w1;
    t_feat_vec    r_x;
    logic [31:0]  r_dot, n_dot;
    logic [62:0]  r_prod;
    logic [31:0]  r_acc;
    logic signed [15:0] pp;
    logic [63:0]  rnd;
    logic [6:0]   y;
    logic signed [15:0] yw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < FEATURES; d++) r_w0[d] <= '0;
            r_b0 <= '0;
            r_w1 <= '0;
        end else if (i_load.en) begin
            if (i_load.kind == LK_W0 && i_load.idx == LOAD_IDX_W'(CELL_IDX)) begin
                for (int k = 0; k < FEATURES; k++) begin
                    if (i_load.be[k]) r_w0[k] <= i_load.word[31 - 8*k -: 8];
                end
            end
            if (i_load.kind == LK_B0 && i_load.idx == LOAD_IDX_W'(CELL_IDX)) begin
                r_b0 <= i_load.word;
            end
            if (i_load.kind == LK_W1 && i_load.idx == LOAD_IDX_W'(W1_WORD)
                    && i_load.be[W1_BYTE]) begin
                r_w1 <= i_load.word[31 - 8*W1_BYTE -: 8];
            end
        end
    end

    always_comb begin
        n_dot = r_b0;
        pp    = '0;
        for (int d = 0; d < FEATURES; d++) begin
            pp    = i_x[d] * r_w0[d];
            n_dot = n_dot + {{16{pp[15]}}, pp};
        end
        // round half up, then clamp to the int8 positive range
        rnd = {1'b0, r_prod} + 64'd8388608;
        y   = (rnd[63:24] > 40'd127) ? 7'd127 : rnd[30:24];
        yw  = $signed({1'b0, y}) * r_w1;
    end

    // three stages: dot product, requantize product, output accumulate
    always_ff @(posedge i_clk) begin
        r_x   <= i_x;
        r_dot <= n_dot;
        if (!r_dot[31] && r_dot != '0) begin
            r_prod <= 63'(r_dot[30:0]) * 63'(i_hidden_mult);
        end else begin
            r_prod <= '0;
        end
        r_acc <= i_acc + {{16{yw[15]}}, yw};
    end

    assign o_x   = r_x;
    assign o_acc = r_acc;
endmodule

### hw/rtl/int8_mlp_score_engine_unit.sv
// int8 mlp score engine top level: channels, config, scaling and cell chain
// depends on imlp_pkg, the channel interfaces, imlp_loader, imlp_cell and the assertion header
//
// usage:
//   i_in carries items; mode 1 items are weight load words, placed in order
//   into the first-layer weights, hidden biases, output weights and output
//   bias. they give no result.
//   mode 0 items carry four features and give one item on o_out with the
//   saturated q16.16 score and a copy of the last marker.
//   i_cfg writes the seven registers by index; it is always ready. the user
//   must write it only while the block is idle; the block does not enforce it.
//   a feature item is multiplied at its accept edge, rounded to int8 in the
//   next cycle, then passes through the chain of neuron cells (the features
//   move one cell per cycle, each cell takes three stages) and through the
//   output scaling, where the product and then the score are registered. the
//   next item is taken only once the score has moved into the result register.
//   the result register frees the input: a new item is taken while a score
//   waits; a stalled receiver holds the next score in the output stage.
//   reset clears all weights and biases to zero, the load counter, and
//   restores the register defaults.
`timescale 1ns / 1ps
`include "int8_mlp_score_engine_unit_assert.svh"
module int8_mlp_score_engine_unit import imlp_pkg::*; #(
    parameter int HIDDEN = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    imlp_in_if.sink         i_in,
    imlp_out_if.source      o_out,
    imlp_cfg_if.sink        i_cfg
);
    localparam int CNT_W = $clog2(HIDDEN + 3);
    localparam logic [CNT_W-1:0] RUN_LAST = CNT_W'(HIDDEN + 2);

    logic [7:0]  r_w0_bytes;
    logic [5:0]  r_b0_words;
    logic [5:0]  r_w1_bytes;
    logic [2:0]  r_b1_words;
    logic [31:0] r_in_mult, r_hid_mult, r_out_mult;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [63:0]      r_fprod [FEATURES];
    logic [FEATURES-1:0] r_fneg;
    logic             r_last;
    t_feat_vec        r_x0;
    logic [31:0]      r_b1;
    logic [63:0]      r_omul;
    logic             r_oneg;
    logic             r_ovalid;
    logic signed [31:0] r_score;
    logic             r_olast;

    logic        in_acc, in_ready, out_free, score_acc, load_wr;
    logic [31:0] mag_of, mag_acc, n_score;
    logic [16:0] mag_im;
    logic [63:0] orr;
    t_load_wr    load;
    t_feat_vec   chain_x   [HIDDEN+1];
    logic [31:0] chain_acc [HIDDEN+1];

    function automatic t_int8 quant_in(input logic [63:0] mag, input logic neg,
                                       input int unsigned f);
        logic [63:0] r;
        r = (mag >> f) + ((mag >> (f - 1)) & 64'd1);
        if (neg) begin
            quant_in = (r > 64'd128) ? -8'sd128 : t_int8'(64'd0 - r);
        end else begin
            quant_in = (r > 64'd127) ? 8'sd127 : t_int8'(r);
        end
    endfunction

    // config registers
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w0_bytes <= 8'd128;
            r_b0_words <= 6'd32;
            r_w1_bytes <= 6'd32;
            r_b1_words <= 3'd1;
            r_in_mult  <= 32'd65536;
            r_hid_mult <= 32'd16777216;
            r_out_mult <= 32'd16777216;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_W0_BYTES: r_w0_bytes <= i_cfg.data[7:0];
                CFG_B0_WORDS: r_b0_words <= i_cfg.data[5:0];
                CFG_W1_BYTES: r_w1_bytes <= i_cfg.data[5:0];
                CFG_B1_WORDS: r_b1_words <= i_cfg.data[2:0];
                CFG_IN_MULT:  r_in_mult  <= i_cfg.data;
                CFG_HID_MULT: r_hid_mult <= i_cfg.data;
                CFG_OUT_MULT: r_out_mult <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // control
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (in_acc && !i_in.mode) n_state = ST_SCALE;
            ST_SCALE: n_state = ST_RUN;
            ST_RUN:   if (r_cnt == RUN_LAST) n_state = ST_OUT;
            ST_OUT:   if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready  = (r_state == ST_IDLE);
        out_free  = !r_ovalid || o_out.ready;
        score_acc = (r_state == ST_OUT) && out_free;
    end

    assign i_in.ready = in_ready;
    assign in_acc     = i_in.valid && in_ready;
    assign load_wr    = in_acc && i_in.mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
            r_b1     <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= (r_state == ST_RUN) ? r_cnt + 1'b1 : '0;
            if (score_acc) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            if (load.en && load.kind == LK_B1) r_b1 <= load.word;
        end
    end

    // input scaling
    always_comb begin
        mag_of = i_in.order_flow[31] ? 32'd0 - i_in.order_flow : i_in.order_flow;
        mag_im = i_in.imbalance[15] ? 17'h10000 - {1'b0, i_in.imbalance}
                                    : {1'b0, i_in.imbalance};
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && !i_in.mode) begin
            r_fprod[0] <= 64'(mag_of) * 64'(r_in_mult);
            r_fprod[1] <= 64'(mag_im) * 64'(r_in_mult);
            r_fprod[2] <= 64'(i_in.burst) * 64'(r_in_mult);
            r_fprod[3] <= 64'(i_in.volatility) * 64'(r_in_mult);
            r_fneg     <= {2'b00, i_in.imbalance[15], i_in.order_flow[31]};
            r_last     <= i_in.last_in;
        end
        if (r_state == ST_SCALE) begin
            r_x0[0] <= quant_in(r_fprod[0], r_fneg[0], 16);
            r_x0[1] <= quant_in(r_fprod[1], r_fneg[1], 31);
            r_x0[2] <= quant_in(r_fprod[2], r_fneg[2], 32);
            r_x0[3] <= quant_in(r_fprod[3], r_fneg[3], 32);
        end
    end

    imlp_loader #(.HIDDEN(HIDDEN)) u_loader (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (load_wr),
        .i_word     (i_in.weight_word),
        .i_w0_bytes (r_w0_bytes),
        .i_b0_words (r_b0_words),
        .i_w1_bytes (r_w1_bytes),
        .i_b1_words (r_b1_words),
        .o_load     (load)
    );

    assign chain_x[0]   = r_x0;
    assign chain_acc[0] = r_b1;

    for (genvar h = 0; h < HIDDEN; h++) begin : g_cell
        imlp_cell #(.CELL_IDX(h)) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_load        (load),
            .i_hidden_mult (r_hid_mult),
            .i_x           (chain_x[h]),
            .i_acc         (chain_acc[h]),
            .o_x           (chain_x[h+1]),
            .o_acc         (chain_acc[h+1])
        );
    end

    // output scaling
    assign mag_acc = chain_acc[HIDDEN][31] ? 32'd0 - chain_acc[HIDDEN] : chain_acc[HIDDEN];

    always_comb begin
        orr = (r_omul >> 8) + ((r_omul >> 7) & 64'd1);
        if (r_oneg) begin
            n_score = (orr > 64'h8000_0000) ? 32'h8000_0000 : 32'(64'd0 - orr);
        end else begin
            n_score = (orr > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : orr[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_RUN && r_cnt == RUN_LAST) begin
            r_omul <= 64'(mag_acc) * 64'(r_out_mult);
            r_oneg <= chain_acc[HIDDEN][31];
        end
        if (score_acc) begin
            r_score <= n_score;
            r_olast <= r_last;
        end
    end

    assign o_out.valid    = r_ovalid;
    assign o_out.score    = r_score;
    assign o_out.last_out = r_olast;

    `IMLP_ASSERT_NEXT(a_feat_starts, i_clk, i_rst_n, in_acc && !i_in.mode, r_state == ST_SCALE)
    `IMLP_ASSERT_IMPL(a_cnt_bound, i_clk, i_rst_n, r_state == ST_RUN, r_cnt <= RUN_LAST)
    `IMLP_ASSERT_NEXT(a_out_src, i_clk, i_rst_n, r_state != ST_OUT && !r_ovalid, !r_ovalid)
endmodule
